[design/sbda_pkg.sv]
`timescale 1ns / 1ps
package sbda_pkg;

   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned DIGITS    = 10;
   localparam int unsigned BCD_W     = 4 * DIGITS;
   localparam int unsigned BIT_CNT_W = $clog2(VALUE_W);
   localparam int unsigned DIG_CNT_W = $clog2(DIGITS + 1);

   localparam logic [7:0] ASCII_ZERO  = 8'd48;
   localparam logic [7:0] ASCII_MINUS = 8'd45;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic convert_step;
      logic skip_step;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic bit_last;
      logic top_zero;
      logic cnt_one;
      logic negative;
      logic out_free;
   } status_type;

endpackage

[design/signed_binary_to_decimal_ascii_core.sv]
`timescale 1ns / 1ps
// After a request is accepted, 32 shift-and-add-3 steps run, then leading zeros are
// dropped one digit at a time, and then the first character is presented.
// Characters then follow one per cycle while rsp_ready holds; up to 11 per request.
// A new request is accepted only in idle, after the last character has been emitted;
// the serial BCD conversion, the leading zero drop and the character output run in turn.
// Reset (synchronous, active high) returns the controller to idle and empties the output.
module signed_binary_to_decimal_ascii_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [31:0]   req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_character,
   output logic                 rsp_last
);

   sbda_pkg::cmd_type    cmd;
   sbda_pkg::status_type status;

   sbda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sbda_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

[design/sbda_datapath.sv]
`timescale 1ns / 1ps
module sbda_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic signed [sbda_pkg::VALUE_W-1:0] req_value,
   input  sbda_pkg::cmd_type           cmd,
   output sbda_pkg::status_type        status,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [7:0]                  rsp_character,
   output logic                        rsp_last
);

   logic [sbda_pkg::VALUE_W-1:0]   mag_ff, mag_in;
   logic [sbda_pkg::BCD_W-1:0]     bcd_ff, bcd_in, bcd_adj;
   logic [sbda_pkg::BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [sbda_pkg::DIG_CNT_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic                           neg_ff, neg_in;
   logic                           out_valid_ff, out_valid_in;
   logic [7:0]                     char_ff, char_in;
   logic                           last_ff, last_in;
   logic [3:0]                     top_digit;

   assign top_digit = bcd_ff[sbda_pkg::BCD_W-1 -: 4];

   // Add three to every BCD digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < int'(sbda_pkg::DIGITS); i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      neg_in     = neg_ff;
      if (cmd.load) begin
         neg_in     = req_value[sbda_pkg::VALUE_W-1];
         mag_in     = req_value[sbda_pkg::VALUE_W-1] ? (~req_value + 1'b1) : req_value;
         bcd_in     = '0;
         bit_cnt_in = sbda_pkg::BIT_CNT_W'(sbda_pkg::VALUE_W - 1);
         dig_cnt_in = sbda_pkg::DIG_CNT_W'(sbda_pkg::DIGITS);
      end else if (cmd.convert_step) begin
         bcd_in     = {bcd_adj[sbda_pkg::BCD_W-2:0], mag_ff[sbda_pkg::VALUE_W-1]};
         mag_in     = {mag_ff[sbda_pkg::VALUE_W-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - 1'b1;
      end else if (cmd.skip_step || cmd.emit_digit) begin
         bcd_in     = {bcd_ff[sbda_pkg::BCD_W-5:0], 4'd0};
         dig_cnt_in = dig_cnt_ff - 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (cmd.emit_sign) begin
         out_valid_in = 1'b1;
         char_in      = sbda_pkg::ASCII_MINUS;
         last_in      = 1'b0;
      end else if (cmd.emit_digit) begin
         out_valid_in = 1'b1;
         char_in      = sbda_pkg::ASCII_ZERO + {4'd0, top_digit};
         last_in      = (dig_cnt_ff == sbda_pkg::DIG_CNT_W'(1));
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
      neg_ff     <= neg_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign status.bit_last = (bit_cnt_ff == '0);
   assign status.top_zero = (top_digit == 4'd0);
   assign status.cnt_one  = (dig_cnt_ff == sbda_pkg::DIG_CNT_W'(1));
   assign status.negative = neg_ff;
   assign status.out_free = ~out_valid_ff | rsp_ready;

   assign rsp_valid     = out_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

[design/sbda_ctrl.sv]
`timescale 1ns / 1ps
module sbda_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sbda_pkg::status_type status,
   output sbda_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CONV   = 3'd1;
   localparam logic [2:0] ST_SKIP   = 3'd2;
   localparam logic [2:0] ST_SIGN   = 3'd3;
   localparam logic [2:0] ST_DIGITS = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.convert_step = 1'b1;
            if (status.bit_last) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // Drop leading zeros but keep at least one digit
            if (status.top_zero && !status.cnt_one) begin
               cmd.skip_step = 1'b1;
            end else if (status.negative) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.cnt_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule
